@@ src/etf_pkg.sv @@
// Shared types and constants for the escape-time fractal iterator.
`default_nettype none

package etf_pkg;

    // Field and register widths
    localparam int ETF_DATA_W    = 32;
    localparam int ETF_PROD_W    = 2 * ETF_DATA_W;
    localparam int ETF_MODE_W    = 3;
    localparam int ETF_LIMIT_W   = 16;
    localparam int ETF_RESULT_W  = 16;
    localparam int ETF_CFG_IDX_W = 2;

    // Number format and counter defaults
    localparam int ETF_FRAC_BITS  = 28;
    localparam int ETF_COUNT_BITS = 16;

    // Register indexes on the configuration port
    localparam logic [ETF_CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [ETF_CFG_IDX_W-1:0] REG_LIMIT      = 2'd1;
    localparam logic [ETF_CFG_IDX_W-1:0] REG_JULIA_REAL = 2'd2;
    localparam logic [ETF_CFG_IDX_W-1:0] REG_JULIA_IMAG = 2'd3;

    // Fractal map codes; unused codes iterate as the plain quadratic map
    localparam logic [ETF_MODE_W-1:0] MODE_MANDEL  = 3'd0;
    localparam logic [ETF_MODE_W-1:0] MODE_JULIA   = 3'd1;
    localparam logic [ETF_MODE_W-1:0] MODE_SHIP    = 3'd2;
    localparam logic [ETF_MODE_W-1:0] MODE_CELTIC  = 3'd3;
    localparam logic [ETF_MODE_W-1:0] MODE_BUFFALO = 3'd4;

    // Reset values of the configuration registers
    localparam logic [ETF_MODE_W-1:0]  RST_MODE  = MODE_MANDEL;
    localparam logic [ETF_LIMIT_W-1:0] RST_LIMIT = 16'd256;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;  // take a new point
        logic mul;   // form the three products of z
        logic chk;   // escape test, combine products
        logic upd;   // write the new z, bump the count
        logic put;   // move the count into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic stop;  // escaped or limit reached (valid in the check step)
    } t_sts;

endpackage

`default_nettype wire

@@ src/etf_ctrl.sv @@
// Controller state machine that sequences one point through the iteration loop.
`default_nettype none

module etf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_out_free,
    input  etf_pkg::t_sts    i_sts,
    output etf_pkg::t_cmd    o_cmd
);
    import etf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.stop ? ST_DONE : ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_MUL;
            end
            ST_DONE: begin
                // hold until the output register can take the count
                if (i_out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    ap_chk_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK) |-> $past(r_state == ST_MUL))
        else $error("check step not preceded by multiply step");

    ap_upd_only_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $past(r_state == ST_CHK && !i_sts.stop))
        else $error("update after a stopping check");

    ap_put_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put |=> (r_state == ST_IDLE))
        else $error("result written but controller not back to idle");
`endif

endmodule

`default_nettype wire

@@ src/etf_dp.sv @@
// Datapath: z registers, shared multipliers, escape test, map update and count.
`default_nettype none

module etf_dp #(
    parameter int COUNT_BITS = etf_pkg::ETF_COUNT_BITS
) (
    input  wire                                   i_clk,
    input  etf_pkg::t_cmd                         i_cmd,
    output etf_pkg::t_sts                         o_sts,
    input  wire signed [etf_pkg::ETF_DATA_W-1:0]  i_point_real,
    input  wire signed [etf_pkg::ETF_DATA_W-1:0]  i_point_imag,
    input  wire        [etf_pkg::ETF_MODE_W-1:0]  i_mode,
    input  wire        [etf_pkg::ETF_LIMIT_W-1:0] i_limit,
    input  wire signed [etf_pkg::ETF_DATA_W-1:0]  i_julia_real,
    input  wire signed [etf_pkg::ETF_DATA_W-1:0]  i_julia_imag,
    output logic       [etf_pkg::ETF_RESULT_W-1:0] o_count
);
    import etf_pkg::*;

    localparam int CNT_W      = (COUNT_BITS < ETF_LIMIT_W) ? COUNT_BITS : ETF_LIMIT_W;
    localparam int ESC_SHIFT  = 2 * ETF_FRAC_BITS + 2;
    localparam bit ESC_NEVER  = (ESC_SHIFT >= ETF_PROD_W);
    localparam logic [ETF_PROD_W-1:0] ESC_LIM = ESC_NEVER ? '0 : (64'd1 << ESC_SHIFT);
    localparam logic signed [ETF_PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ETF_PROD_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    function automatic logic signed [ETF_DATA_W-1:0] sat_word(
        input logic signed [ETF_PROD_W-1:0] v
    );
        logic signed [ETF_DATA_W-1:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[ETF_DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[ETF_DATA_W-1:0];
        end else begin
            res = v[ETF_DATA_W-1:0];
        end
        return res;
    endfunction

    logic signed [ETF_DATA_W-1:0] r_re;
    logic signed [ETF_DATA_W-1:0] r_im;
    logic signed [ETF_DATA_W-1:0] r_ar;
    logic signed [ETF_DATA_W-1:0] r_ai;
    logic signed [ETF_PROD_W-1:0] r_rr;
    logic signed [ETF_PROD_W-1:0] r_ii;
    logic signed [ETF_PROD_W-1:0] r_ri;
    logic signed [ETF_PROD_W-1:0] r_d;
    logic signed [ETF_PROD_W-1:0] r_np;
    logic        [CNT_W-1:0]      r_cnt;

    logic        [ETF_PROD_W-1:0] w_sum;
    logic                         w_inside;
    logic        [CNT_W-1:0]      w_limit;
    logic signed [ETF_PROD_W-1:0] w_d;
    logic signed [ETF_PROD_W-1:0] w_np;
    logic signed [ETF_PROD_W-1:0] w_nd;
    logic signed [ETF_PROD_W-1:0] w_re_full;
    logic signed [ETF_PROD_W-1:0] w_im_full;
    logic                         w_abs_mode;

    // Escape test on the squares of the current z; both are non-negative
    assign w_sum    = r_rr + r_ii;
    assign w_inside = ESC_NEVER || (w_sum <= ESC_LIM);
    assign w_limit  = i_limit[CNT_W-1:0];
    assign o_sts.stop = (r_cnt == w_limit) || !w_inside;

    assign w_d = r_rr - r_ii;

    // Imaginary product term, already carrying the sign that the map wants
    always_comb begin
        unique case (i_mode)
            MODE_SHIP:    w_np = r_ri[ETF_PROD_W-1] ? r_ri : -r_ri;
            MODE_CELTIC:  w_np = -r_ri;
            MODE_BUFFALO: w_np = r_im[ETF_DATA_W-1] ? r_ri : -r_ri;
            default:      w_np = r_ri;
        endcase
    end

    assign w_abs_mode = (i_mode == MODE_CELTIC) || (i_mode == MODE_BUFFALO);
    assign w_nd       = (w_abs_mode && r_d[ETF_PROD_W-1]) ? -r_d : r_d;

    // Floor shift back to the word format; the doubling folds into the shift
    assign w_re_full = (w_nd >>> ETF_FRAC_BITS) + ETF_PROD_W'(r_ar);
    assign w_im_full = (r_np >>> (ETF_FRAC_BITS - 1)) + ETF_PROD_W'(r_ai);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re  <= i_point_real;
            r_im  <= i_point_imag;
            r_ar  <= (i_mode == MODE_JULIA) ? i_julia_real : i_point_real;
            r_ai  <= (i_mode == MODE_JULIA) ? i_julia_imag : i_point_imag;
            r_cnt <= '0;
        end
        if (i_cmd.mul) begin
            r_rr <= r_re * r_re;
            r_ii <= r_im * r_im;
            r_ri <= r_re * r_im;
        end
        if (i_cmd.chk) begin
            r_d  <= w_d;
            r_np <= w_np;
        end
        if (i_cmd.upd) begin
            r_re  <= sat_word(w_re_full);
            r_im  <= sat_word(w_im_full);
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_count = ETF_RESULT_W'(r_cnt);

endmodule

`default_nettype wire

@@ src/escape_time_fractal_iterator.sv @@
// Top level: configuration registers, input handshake, output register.
// From input transaction to a registered result, a point passes n rounds of multiply,
//   check and update, where n is the number of iterations done (0 to iteration_limit),
//   then a last multiply and check. Only one point is in flight at a time;
//   a stalled result holds the controller until the output register frees.
// Reset (synchronous, active low): controller idle, output empty, mode 0, limit 256, julia 0.
`default_nettype none

module escape_time_fractal_iterator #(
    parameter int COUNT_BITS = etf_pkg::ETF_COUNT_BITS
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // config port
    input  wire                                     i_cfg_we,
    input  wire [etf_pkg::ETF_CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [etf_pkg::ETF_DATA_W-1:0]           i_cfg_wdata,
    // input stream
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire [2*etf_pkg::ETF_DATA_W-1:0]         s_tdata,  // [31:0] point_real, [63:32] point_imag
    // output stream
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [etf_pkg::ETF_RESULT_W-1:0]        m_tdata   // [15:0] iteration_count
);
    import etf_pkg::*;

    logic        [ETF_MODE_W-1:0]   r_mode;
    logic        [ETF_LIMIT_W-1:0]  r_limit;
    logic signed [ETF_DATA_W-1:0]   r_julia_real;
    logic signed [ETF_DATA_W-1:0]   r_julia_imag;
    logic                           r_m_tvalid;
    logic        [ETF_RESULT_W-1:0] r_m_tdata;
    logic                           n_m_tvalid;

    t_cmd                           w_cmd;
    t_sts                           w_sts;
    logic                           w_out_free;
    logic        [ETF_RESULT_W-1:0] w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= RST_MODE;
            r_limit      <= RST_LIMIT;
            r_julia_real <= '0;
            r_julia_imag <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:       r_mode       <= i_cfg_wdata[ETF_MODE_W-1:0];
                REG_LIMIT:      r_limit      <= i_cfg_wdata[ETF_LIMIT_W-1:0];
                REG_JULIA_REAL: r_julia_real <= i_cfg_wdata;
                REG_JULIA_IMAG: r_julia_imag <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_m_tvalid || m_tready;

    etf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    etf_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_point_real (s_tdata[ETF_DATA_W-1:0]),
        .i_point_imag (s_tdata[2*ETF_DATA_W-1:ETF_DATA_W]),
        .i_mode       (r_mode),
        .i_limit      (r_limit),
        .i_julia_real (r_julia_real),
        .i_julia_imag (r_julia_imag),
        .o_count      (w_count)
    );

    // Output register: load on put, drop once the transaction completes
    always_comb begin
        n_m_tvalid = r_m_tvalid;
        if (w_cmd.put) begin
            n_m_tvalid = 1'b1;
        end else if (m_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else begin
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.put) begin
            r_m_tdata <= w_count;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

`ifndef ASSERT_OFF
    ap_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second point taken while one is in flight");

    ap_put_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put |-> (!r_m_tvalid || m_tready))
        else $error("result overwrote an untaken result");
`endif

endmodule

`default_nettype wire
